>>> hw/rtl/kmst_pkg.sv
// Shared types and constants for the keyed max score table.
package kmst_pkg;

   // Field widths of the key, value and result count.
   localparam int KEY_LO_W  = 64;
   localparam int KEY_HI_W  = 24;
   localparam int KEY_W     = KEY_LO_W + KEY_HI_W;
   localparam int KEY_BYTES = KEY_W / 8;
   localparam int VALUE_W   = 32;
   localparam int USED_W    = 5;
   localparam int CMD_W     = 2;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SUBMIT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // Lookup token that travels down the row of cells.
   typedef struct packed {
      logic                do_submit;
      logic [KEY_LO_W-1:0] key_lo;
      logic [KEY_HI_W-1:0] key_hi;
      logic [VALUE_W-1:0]  value;
      logic                found;
      logic                accepted;
      logic                append;
      logic [VALUE_W-1:0]  stored;
   } probe_type;

endpackage

>>> hw/rtl/kmst_norm.sv
// Key normalization: keeps the first KEY_CHARS characters and zeroes everything after a NUL.
module kmst_norm #(
   parameter int KEY_CHARS = 11
) (
   input  logic [kmst_pkg::KEY_LO_W-1:0] raw_lo,
   input  logic [kmst_pkg::KEY_HI_W-1:0] raw_hi,
   output logic [kmst_pkg::KEY_LO_W-1:0] norm_lo,
   output logic [kmst_pkg::KEY_HI_W-1:0] norm_hi
);
   import kmst_pkg::*;

   logic [KEY_W-1:0] raw_key;
   logic [KEY_W-1:0] norm_key;

   assign raw_key = {raw_hi, raw_lo};

   // Walk the characters in order; once a NUL is seen, all later characters read as zero.
   always_comb begin
      logic       ended;
      logic [7:0] chr;
      ended    = 1'b0;
      norm_key = '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         chr = raw_key[8*i +: 8];
         if (i >= KEY_CHARS || ended) begin
            chr = 8'd0;
         end
         if (chr == 8'd0) begin
            ended = 1'b1;
         end
         norm_key[8*i +: 8] = chr;
      end
   end

   assign norm_lo = norm_key[KEY_LO_W-1:0];
   assign norm_hi = norm_key[KEY_W-1:KEY_LO_W];

endmodule

>>> hw/rtl/kmst_cell.sv
// One table entry: holds a key and its best value, checks and updates the passing lookup token.
module kmst_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [CNT_W-1:0]    count,
   input  logic                in_valid,
   input  kmst_pkg::probe_type in_probe,
   output logic                out_valid,
   output kmst_pkg::probe_type out_probe
);
   import kmst_pkg::*;

   logic [KEY_LO_W-1:0] key_lo_ff;
   logic [KEY_HI_W-1:0] key_hi_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic                valid_ff;
   probe_type           probe_ff;
   probe_type           probe_in;
   logic                in_use;
   logic                is_free;
   logic                key_match;
   logic                write_key;
   logic                write_value;

   // This cell is occupied below the fill count and is the append slot at the fill count.
   assign in_use    = count > CNT_W'(IDX);
   assign is_free   = count == CNT_W'(IDX);
   assign key_match = in_use && (key_lo_ff == in_probe.key_lo) && (key_hi_ff == in_probe.key_hi);

   // Update the token and decide whether this entry is written.
   always_comb begin
      probe_in    = in_probe;
      write_key   = 1'b0;
      write_value = 1'b0;
      if (in_valid && !in_probe.found) begin
         if (key_match) begin
            probe_in.found = 1'b1;
            if (in_probe.do_submit && (in_probe.value > value_ff)) begin
               write_value       = 1'b1;
               probe_in.accepted = 1'b1;
               probe_in.stored   = in_probe.value;
            end else begin
               probe_in.stored = value_ff;
            end
         end else if (is_free && in_probe.do_submit && (in_probe.value != '0)) begin
            write_key         = 1'b1;
            write_value       = 1'b1;
            probe_in.found    = 1'b1;
            probe_in.accepted = 1'b1;
            probe_in.append   = 1'b1;
            probe_in.stored   = in_probe.value;
         end
      end
   end

   // Entry storage; contents are undefined until the first append.
   always_ff @(posedge clock) begin
      if (write_key) begin
         key_lo_ff <= in_probe.key_lo;
         key_hi_ff <= in_probe.key_hi;
      end
      if (write_value) begin
         value_ff <= in_probe.value;
      end
      probe_ff <= probe_in;
   end

   // Token valid moves one cell per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_probe = probe_ff;

endmodule

>>> hw/rtl/keyed_max_score_table.sv
// Top level of the keyed max score table: input stage, row of entry cells, result register.
// A query or submit is registered in the input stage, then its lookup token walks the row of
// cells one entry per cycle and the result is registered before rsp_tvalid. A clear skips the row.
// Throughput: one transaction at a time; req_tready returns once the result moves to the
// output register.
// Reset: synchronous, active high; empties the table and drops any transaction in flight.
module keyed_max_score_table_top #(
   parameter int MAX_ENTRIES = 16,
   parameter int KEY_CHARS   = 11
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,  // key_chars_low[63:0], key_chars_high[87:64], new_value[119:88]
   input  logic [2:0]   req_tuser,  // cmd[1:0], key_too_long[2]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,  // stored_value[31:0], used_entries[36:32], zero[39:37]
   output logic [1:0]   rsp_tuser   // accepted[0], key_found[1]
);
   import kmst_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                start_valid_ff, start_valid_in;
   probe_type           start_ff, start_in;
   logic                res_accepted_ff, res_accepted_in;
   logic                res_found_ff, res_found_in;
   logic [VALUE_W-1:0]  res_stored_ff, res_stored_in;
   logic [USED_W-1:0]   res_used_ff, res_used_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [39:0]         rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]          rsp_tuser_ff, rsp_tuser_in;

   logic [CMD_W-1:0]    req_cmd;
   logic                req_too_long;
   logic [KEY_LO_W-1:0] norm_lo;
   logic [KEY_HI_W-1:0] norm_hi;
   logic                req_fire;
   logic                rsp_free;

   logic                chain_valid [MAX_ENTRIES+1];
   probe_type           chain_probe [MAX_ENTRIES+1];

   assign req_cmd      = req_tuser[CMD_W-1:0];
   assign req_too_long = req_tuser[CMD_W];
   assign req_tready   = (state_ff == ST_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign rsp_free     = !rsp_tvalid_ff || rsp_tready;

   // Normalize the incoming key.
   kmst_norm #(
      .KEY_CHARS (KEY_CHARS)
   ) u_norm (
      .raw_lo  (req_tdata[KEY_LO_W-1:0]),
      .raw_hi  (req_tdata[KEY_W-1:KEY_LO_W]),
      .norm_lo (norm_lo),
      .norm_hi (norm_hi)
   );

   // Build the lookup token for a query or submit.
   always_comb begin
      start_in           = '0;
      start_in.do_submit = (req_cmd == CMD_SUBMIT) && !req_too_long;
      start_in.key_lo    = norm_lo;
      start_in.key_hi    = norm_hi;
      start_in.value     = req_tdata[KEY_W +: VALUE_W];
      start_valid_in     = req_fire && (req_cmd != CMD_CLEAR);
   end

   // Row of entry cells.
   assign chain_valid[0] = start_valid_ff;
   assign chain_probe[0] = start_ff;

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      kmst_cell #(
         .IDX   (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .count     (count_ff),
         .in_valid  (chain_valid[g]),
         .in_probe  (chain_probe[g]),
         .out_valid (chain_valid[g+1]),
         .out_probe (chain_probe[g+1])
      );
   end

   // Sequencer: clear finishes at once, lookups wait for the token to leave the row.
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      res_accepted_in = res_accepted_ff;
      res_found_in    = res_found_ff;
      res_stored_in   = res_stored_ff;
      res_used_in     = res_used_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_cmd == CMD_CLEAR) begin
                  count_in        = '0;
                  res_accepted_in = 1'b1;
                  res_found_in    = 1'b0;
                  res_stored_in   = '0;
                  res_used_in     = '0;
                  state_in        = ST_DONE;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (chain_valid[MAX_ENTRIES]) begin
               if (chain_probe[MAX_ENTRIES].append) begin
                  count_in = count_ff + CNT_W'(1);
               end
               res_accepted_in = chain_probe[MAX_ENTRIES].accepted;
               res_found_in    = chain_probe[MAX_ENTRIES].found;
               res_stored_in   = chain_probe[MAX_ENTRIES].stored;
               res_used_in     = USED_W'(count_in);
               state_in        = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {3'b000, res_used_ff, res_stored_ff};
         rsp_tuser_in  = {res_found_ff, res_accepted_ff};
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         start_valid_ff <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         start_valid_ff <= start_valid_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      start_ff        <= start_in;
      res_accepted_ff <= res_accepted_in;
      res_found_ff    <= res_found_in;
      res_stored_ff   <= res_stored_in;
      res_used_ff     <= res_used_in;
      rsp_tdata_ff    <= rsp_tdata_in;
      rsp_tuser_ff    <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

>>> hw/rtl/kmst_checker.sv
// Port-level checks for the keyed max score table, bound to the top level.
module kmst_checker #(
   parameter int MAX_ENTRIES = 16
) (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [39:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   // A stalled result transaction holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // The fill count never exceeds the table size.
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (MAX_ENTRIES >= 31) || (rsp_tdata[36:32] <= MAX_ENTRIES))
      else $error("used entries above table size");

   // A missing key always reports a zero value.
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[31:0] == 32'd0)
      else $error("absent key with nonzero value");

   // An accepted submit leaves a nonzero value under the key.
   a_accept_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && rsp_tuser[1] |-> rsp_tdata[31:0] != 32'd0)
      else $error("accepted submit with zero value");

   // An accepted transaction without a key is a clear and reports an empty table.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && !rsp_tuser[1] |-> rsp_tdata[36:0] == 37'd0)
      else $error("clear did not report an empty table");

endmodule

bind keyed_max_score_table_top kmst_checker #(
   .MAX_ENTRIES (MAX_ENTRIES)
) u_kmst_checker (.*);
